// ===== rtl/rsi_pkg.sv =====
// Shared types, widths and constants for the relative strength index block.
package rsi_pkg;

   localparam int PRICE_W   = 32;
   localparam int PCT_W     = 32;
   localparam int PCT_FRAC  = 16;
   localparam int RSI_W     = 15;
   localparam int PERIOD_W  = 8;
   localparam int COUNT_W   = 9;
   localparam int AVG_W     = 48;
   localparam int DEN_W     = AVG_W + 1;
   localparam int SCALED_W  = PRICE_W + 7;
   localparam int PCT_HI_W  = SCALED_W + PCT_FRAC - PCT_W;
   localparam int RSI_STEPS = RSI_W;
   localparam int NUM_W     = AVG_W + RSI_STEPS;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET  = 8'd14;
   localparam logic [PERIOD_W-1:0] PERIOD_MIN    = 8'd2;
   localparam logic [COUNT_W-1:0]  COUNT_MAX     = 9'd511;
   localparam logic [PCT_W-1:0]    PCT_OFFSET    = 32'h0064_0000;
   localparam logic [PCT_W-1:0]    PCT_SAT_LIMIT = 32'h8063_FFFF;
   localparam logic [PCT_W-1:0]    PCT_MAX       = 32'h7FFF_FFFF;
   localparam logic [RSI_W-1:0]    RSI_FULL      = 15'd25600;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_WARMUP,
      STATUS_FLAT,
      STATUS_PREV_ZERO
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PCT_PREP,
      ST_PCT_DIV,
      ST_ACCUM,
      ST_LANE_START,
      ST_LANE_DIV,
      ST_RSI_PREP,
      ST_RSI_DIV,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [PRICE_W-1:0] price;
   } req_payload_type;

   typedef struct packed {
      logic [RSI_W-1:0]        rsi;
      logic signed [PCT_W-1:0] gain_percent;
      status_type              status;
   } rsp_payload_type;

   typedef struct packed {
      logic [PERIOD_W-1:0] period;
   } csr_payload_type;

endpackage

// ===== rtl/rsi_chan_if.sv =====
// Valid/ready channel interface carrying one payload word.
interface rsi_chan_if #(parameter type payload_type = logic);

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

// ===== rtl/rsi_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
module rsi_div #(
   parameter int  DW = 49,
   parameter int  QW = 32,
   localparam int CW = $clog2(QW + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [CW-1:0] steps,
   input  logic [DW-1:0] rem_init,
   input  logic [QW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic          busy,
   output logic [QW-1:0] quotient
);

   logic [DW-1:0] rem_ff, rem_in;
   logic [QW-1:0] shf_ff, shf_in;
   logic [DW-1:0] dvs_ff, dvs_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW:0]   trial;
   logic [DW:0]   diff;
   logic          fits;

   // rem_ff stays below the divisor, so one trial subtract settles each bit
   assign trial = {rem_ff, shf_ff[QW-1]};
   assign fits  = trial >= {1'b0, dvs_ff};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      rem_in = rem_ff;
      shf_in = shf_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      if (start) begin
         rem_in = rem_init;
         shf_in = dividend;
         dvs_in = divisor;
         cnt_in = steps;
      end else if (cnt_ff != '0) begin
         rem_in = fits ? diff[DW-1:0] : trial[DW-1:0];
         shf_in = {shf_ff[QW-2:0], fits};
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      shf_ff <= shf_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = cnt_ff != '0;
   assign quotient = shf_ff;

endmodule

// ===== rtl/relative_strength_index.sv =====
// Relative strength index: takes one price word, returns one RSI result word per price.
// The 32-step percent division, the 48-step smoothing lanes and the 15-step RSI division
// run one quotient bit per cycle, in sequence; the first price skips them all and warm-up
// prices skip the lanes and the RSI division. A new price is taken only in idle, after the
// previous result has been handed to the result register.
// Reset: synchronous, clears state, averages and price history, period returns to 14.
module relative_strength_index (
   input logic        clock,
   input logic        reset,
   rsi_chan_if.sink   csr_ch,
   rsi_chan_if.sink   req_ch,
   rsi_chan_if.source rsp_ch
);

   import rsi_pkg::*;

   localparam int MAIN_CW  = $clog2(PCT_W + 1);
   localparam int LANE_CW  = $clog2(AVG_W + 1);
   localparam int DIFF_W   = AVG_W + 2;
   localparam int PCT_N1_W = SCALED_W + PCT_FRAC;

   // Control and history state
   state_type              state_ff, state_in;
   logic [PERIOD_W-1:0]    period_ff, period_in;
   logic [PRICE_W-1:0]     prev_ff, prev_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [AVG_W-1:0]       avg_gain_ff, avg_gain_in;
   logic [AVG_W-1:0]       avg_loss_ff, avg_loss_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Per-item working registers
   logic [PRICE_W-1:0]     cur_ff, cur_in;
   logic signed [PCT_W-1:0] chg_ff, chg_in;
   logic [RSI_W-1:0]       rsi_ff, rsi_in;
   status_type             status_ff, status_in;
   logic                   warm_ff, warm_in;
   logic                   gain_neg_ff, gain_neg_in;
   logic                   loss_neg_ff, loss_neg_in;
   rsp_payload_type        rsp_data_ff, rsp_data_in;

   // Decodes of the stored state
   logic [PERIOD_W-1:0]    p_eff;
   logic [COUNT_W-1:0]     p_ext;
   logic                   count_zero, count_lt_p, count_eq_p, count_gt_p;
   logic                   prev_zero;

   // Percent change datapath
   logic [SCALED_W-1:0]    scaled;
   logic [PCT_N1_W-1:0]    pct_num;
   logic [PCT_HI_W-1:0]    pct_hi;
   logic                   pct_sat;

   // Averages datapath
   logic [PCT_W-1:0]       gain_in, loss_in;
   logic [DIFF_W-1:0]      gain_diff, loss_diff, gain_abs, loss_abs;
   logic [AVG_W-1:0]       gain_dvd, loss_dvd;
   logic [NUM_W-1:0]       rsi_num;
   logic [DEN_W-1:0]       rsi_den;

   // Divider hookup
   logic                   main_start, main_busy;
   logic [MAIN_CW-1:0]     main_steps;
   logic [DEN_W-1:0]       main_rem_init, main_divisor;
   logic [PCT_W-1:0]       main_dividend, main_quo;
   logic                   lane_start, gain_busy, loss_busy;
   logic [AVG_W-1:0]       gain_quo, loss_quo;

   // Periods below the minimum act as the minimum
   assign p_eff      = (period_ff < PERIOD_MIN) ? PERIOD_MIN : period_ff;
   assign p_ext      = {1'b0, p_eff};
   assign count_zero = count_ff == '0;
   assign count_lt_p = count_ff < p_ext;
   assign count_eq_p = count_ff == p_ext;
   assign count_gt_p = count_ff > p_ext;
   assign prev_zero  = prev_ff == '0;

   // cur * 100 as shifts and adds, then scaled up to Q16.16. A high half at or above
   // the previous price means a quotient of 2^32 or more: saturate without dividing.
   assign scaled  = (SCALED_W'(cur_ff) << 6) + (SCALED_W'(cur_ff) << 5)
                  + (SCALED_W'(cur_ff) << 2);
   assign pct_num = {scaled, {PCT_FRAC{1'b0}}};
   assign pct_hi  = pct_num[PCT_N1_W-1:PCT_W];
   assign pct_sat = {{(PRICE_W-PCT_HI_W){1'b0}}, pct_hi} >= prev_ff;

   // Split the change into gain and loss magnitudes
   assign gain_in = chg_ff[PCT_W-1] ? '0 : PCT_W'(chg_ff);
   assign loss_in = chg_ff[PCT_W-1] ? PCT_W'((~chg_ff) + PCT_W'(1)) : '0;

   // Smoothing step is (target - avg) / period, truncated toward zero: divide the
   // magnitude and put the sign back when the lane finishes.
   assign gain_diff = {{(DIFF_W-PCT_W){1'b0}}, gain_in} - {2'b00, avg_gain_ff};
   assign loss_diff = {{(DIFF_W-PCT_W){1'b0}}, loss_in} - {2'b00, avg_loss_ff};
   assign gain_abs  = gain_diff[DIFF_W-1] ? (~gain_diff) + DIFF_W'(1) : gain_diff;
   assign loss_abs  = loss_diff[DIFF_W-1] ? (~loss_diff) + DIFF_W'(1) : loss_diff;

   // At the end of warm-up the lanes divide the sums instead
   assign gain_dvd = count_eq_p ? avg_gain_ff : gain_abs[AVG_W-1:0];
   assign loss_dvd = count_eq_p ? avg_loss_ff : loss_abs[AVG_W-1:0];

   // gain * 25600 = gain * (2^14 + 2^13 + 2^10); the quotient over gain + loss
   // never exceeds 25600, so 15 quotient bits cover it.
   assign rsi_num = (NUM_W'(avg_gain_ff) << 14) + (NUM_W'(avg_gain_ff) << 13)
                  + (NUM_W'(avg_gain_ff) << 10);
   assign rsi_den = {1'b0, avg_gain_ff} + {1'b0, avg_loss_ff};

   // Configuration: always ready; the user writes it only while idle, as the block itself does not enforce it
   assign csr_ch.ready = 1'b1;
   assign period_in    = csr_ch.valid ? csr_ch.payload.period : period_ff;

   // Sequencer: next state, working registers and divider commands
   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      chg_in        = chg_ff;
      rsi_in        = rsi_ff;
      status_in     = status_ff;
      warm_in       = warm_ff;
      gain_neg_in   = gain_neg_ff;
      loss_neg_in   = loss_neg_ff;
      avg_gain_in   = avg_gain_ff;
      avg_loss_in   = avg_loss_ff;
      prev_in       = prev_ff;
      count_in      = count_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ch.ready;
      req_ch.ready  = 1'b0;
      main_start    = 1'b0;
      main_steps    = MAIN_CW'(PCT_W);
      main_rem_init = {{(DEN_W-PCT_HI_W){1'b0}}, pct_hi};
      main_dividend = pct_num[PCT_W-1:0];
      main_divisor  = {{(DEN_W-PRICE_W){1'b0}}, prev_ff};
      lane_start    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               cur_in = req_ch.payload.price;
               chg_in = '0;
               if (count_zero) begin
                  // first price: nothing to compare against
                  rsi_in    = '0;
                  status_in = STATUS_WARMUP;
                  state_in  = ST_FINISH;
               end else if (prev_zero) begin
                  // count the change as a zero gain
                  state_in = ST_ACCUM;
               end else begin
                  state_in = ST_PCT_PREP;
               end
            end
         end
         ST_PCT_PREP: begin
            if (pct_sat) begin
               chg_in   = PCT_MAX;
               state_in = ST_ACCUM;
            end else begin
               main_start = 1'b1;
               state_in   = ST_PCT_DIV;
            end
         end
         ST_PCT_DIV: begin
            if (!main_busy) begin
               chg_in   = (main_quo > PCT_SAT_LIMIT) ? PCT_MAX : main_quo - PCT_OFFSET;
               state_in = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            // warm-up: add into the running sums
            if (!count_gt_p) begin
               avg_gain_in = avg_gain_ff + AVG_W'(gain_in);
               avg_loss_in = avg_loss_ff + AVG_W'(loss_in);
            end
            state_in = count_lt_p ? ST_RSI_PREP : ST_LANE_START;
         end
         ST_LANE_START: begin
            lane_start  = 1'b1;
            warm_in     = count_eq_p;
            gain_neg_in = gain_diff[DIFF_W-1];
            loss_neg_in = loss_diff[DIFF_W-1];
            state_in    = ST_LANE_DIV;
         end
         ST_LANE_DIV: begin
            if (!gain_busy && !loss_busy) begin
               if (warm_ff) begin
                  avg_gain_in = gain_quo;
                  avg_loss_in = loss_quo;
               end else begin
                  avg_gain_in = gain_neg_ff ? avg_gain_ff - gain_quo : avg_gain_ff + gain_quo;
                  avg_loss_in = loss_neg_ff ? avg_loss_ff - loss_quo : avg_loss_ff + loss_quo;
               end
               state_in = ST_RSI_PREP;
            end
         end
         ST_RSI_PREP: begin
            rsi_in = '0;
            if (prev_zero) begin
               status_in = STATUS_PREV_ZERO;
               state_in  = ST_FINISH;
            end else if (count_lt_p) begin
               status_in = STATUS_WARMUP;
               state_in  = ST_FINISH;
            end else if (rsi_den == '0) begin
               status_in = STATUS_FLAT;
               state_in  = ST_FINISH;
            end else begin
               main_start    = 1'b1;
               main_steps    = MAIN_CW'(RSI_STEPS);
               main_rem_init = {1'b0, rsi_num[NUM_W-1:RSI_STEPS]};
               main_dividend = {rsi_num[RSI_STEPS-1:0], {(PCT_W-RSI_STEPS){1'b0}}};
               main_divisor  = rsi_den;
               state_in      = ST_RSI_DIV;
            end
         end
         ST_RSI_DIV: begin
            if (!main_busy) begin
               rsi_in    = main_quo[RSI_W-1:0];
               status_in = STATUS_OK;
               state_in  = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold until the result register is free, then commit the price history
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.rsi          = rsi_ff;
               rsp_data_in.gain_percent = chg_ff;
               rsp_data_in.status       = status_ff;
               prev_in                  = cur_ff;
               count_in = (count_ff == COUNT_MAX) ? count_ff : count_ff + COUNT_W'(1);
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         period_ff    <= PERIOD_RESET;
         prev_ff      <= '0;
         count_ff     <= '0;
         avg_gain_ff  <= '0;
         avg_loss_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         period_ff    <= period_in;
         prev_ff      <= prev_in;
         count_ff     <= count_in;
         avg_gain_ff  <= avg_gain_in;
         avg_loss_ff  <= avg_loss_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      chg_ff      <= chg_in;
      rsi_ff      <= rsi_in;
      status_ff   <= status_in;
      warm_ff     <= warm_in;
      gain_neg_ff <= gain_neg_in;
      loss_neg_ff <= loss_neg_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_data_ff;

   // Shared divider: percent change first, RSI ratio last
   rsi_div #(
      .DW (DEN_W),
      .QW (PCT_W)
   ) u_main_div (
      .clock    (clock),
      .reset    (reset),
      .start    (main_start),
      .steps    (main_steps),
      .rem_init (main_rem_init),
      .dividend (main_dividend),
      .divisor  (main_divisor),
      .busy     (main_busy),
      .quotient (main_quo)
   );

   // Gain and loss lanes divide by the period side by side
   rsi_div #(
      .DW (PERIOD_W),
      .QW (AVG_W)
   ) u_gain_div (
      .clock    (clock),
      .reset    (reset),
      .start    (lane_start),
      .steps    (LANE_CW'(AVG_W)),
      .rem_init ('0),
      .dividend (gain_dvd),
      .divisor  (p_eff),
      .busy     (gain_busy),
      .quotient (gain_quo)
   );

   rsi_div #(
      .DW (PERIOD_W),
      .QW (AVG_W)
   ) u_loss_div (
      .clock    (clock),
      .reset    (reset),
      .start    (lane_start),
      .steps    (LANE_CW'(AVG_W)),
      .rem_init ('0),
      .dividend (loss_dvd),
      .divisor  (p_eff),
      .busy     (loss_busy),
      .quotient (loss_quo)
   );

endmodule

// ===== rtl/rsi_checker.sv =====
// Port-level checks on the result channel, bound to the top level.
module rsi_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input rsi_pkg::rsp_payload_type rsp_payload
);

   import rsi_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result word changed while stalled");

   a_rsi_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.rsi <= RSI_FULL)
      else $error("rsi above 100.0");

   a_rsi_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != STATUS_OK |-> rsp_payload.rsi == '0)
      else $error("rsi nonzero without ok status");

   a_prev_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == STATUS_PREV_ZERO |-> rsp_payload.gain_percent == '0)
      else $error("percent change nonzero after zero price");

endmodule

bind relative_strength_index rsi_checker u_rsi_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_payload (rsp_ch.payload)
);
